>>> src/bounded_double_ended_queue_core_defines.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BDQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double-ended queue check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double-ended queue check failed");

`endif

>>> src/bdq_pkg.sv
// Package with codes, types and defaults of the double-ended queue.
package bdq_pkg;

  // Default number of entries in the store.
  localparam int DEPTH_DEFAULT = 32;

  // Operation codes carried on the mode port.
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_DROP_FIRST = 3'd2;
  localparam logic [2:0] MODE_DROP_LAST  = 3'd3;
  localparam logic [2:0] MODE_DUMP       = 3'd4;

  // Status codes carried on the status port.
  localparam logic [2:0] STATUS_DONE  = 3'd0;
  localparam logic [2:0] STATUS_EMPTY = 3'd1;
  localparam logic [2:0] STATUS_FULL  = 3'd2;
  localparam logic [2:0] STATUS_ELEM  = 3'd3;
  localparam logic [2:0] STATUS_COUNT = 3'd4;

  // Control states: waiting for a command, streaming a dump, closing a dump.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP,
    ST_CLOSE
  } state_t;

endpackage

>>> src/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Commands enter on start/mode/value and are taken at a rising edge where
// start is high and busy is low. Results leave on status, element,
// position, count and last, each beat marked by strobe for exactly one
// cycle; the receiver cannot hold a beat off, so there is no stall path.
// Push and drop commands: the result beat appears in the cycle after the
// command beat, and busy stays low, so a new command can be taken in every
// cycle. A dump of an empty queue behaves the same way with a single count
// beat. A dump of n elements reads the store one entry per cycle through
// its single read port: the dump state and then the registered read lead
// to the first element beat, one more follows in each cycle, then one count
// beat with last set. Busy is high through the dump and closing states and
// is low again in the cycle that carries the count beat. The store sits in
// one synchronous memory with a registered read; writes happen only for
// commands taken while idle, so none can overlap a dump. A synchronous
// reset empties the queue and clears the front index; memory contents are
// left as they are and are never read before a push writes them.
`include "bounded_double_ended_queue_core_defines.svh"

module bounded_double_ended_queue_core #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] element,
  output logic [4:0]         position,
  output logic [5:0]         count,
  output logic               last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W:0] SUM_DEPTH = (CNT_W + 1)'(DEPTH);

  // Element store.
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;

  // Control and queue state.
  bdq_pkg::state_t state, state_next;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [IDX_W-1:0] idx, idx_next;

  // Result registers.
  logic strobe_next;
  logic [2:0] status_next;
  logic [IDX_W-1:0] pos_q, pos_next;
  logic elem_sel, elem_sel_next;
  logic last_next;

  // Memory write port.
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;

  // Derived addresses and flags.
  logic accept;
  logic full;
  logic empty;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] ptr_inc;
  logic [CNT_W:0] back_sum;
  logic [CNT_W:0] back_wrap;
  logic [IDX_W-1:0] back_addr;
  logic [CNT_W-1:0] idx_plus;
  logic dump_end;
  logic [IDX_W+4:0] pos_ext;
  logic [CNT_W+5:0] cnt_ext;

  assign busy   = (state != bdq_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (occ == CNT_FULL);
  assign empty  = (occ == '0);

  // Circular index arithmetic for any depth.
  assign front_dec = (front == '0) ? IDX_MAX : front - 1'b1;
  assign front_inc = (front == IDX_MAX) ? '0 : front + 1'b1;
  assign ptr_inc   = (ptr == IDX_MAX) ? '0 : ptr + 1'b1;
  assign back_sum  = (CNT_W + 1)'(front) + (CNT_W + 1)'(occ);
  assign back_wrap = (back_sum >= SUM_DEPTH) ? back_sum - SUM_DEPTH : back_sum;
  assign back_addr = back_wrap[IDX_W-1:0];
  assign idx_plus  = CNT_W'(idx) + 1'b1;
  assign dump_end  = (idx_plus == occ);

  // Next state of the controller.
  always_comb begin
    state_next = state;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (accept && mode == bdq_pkg::MODE_DUMP && !empty) begin
          state_next = bdq_pkg::ST_DUMP;
        end
      end
      bdq_pkg::ST_DUMP: begin
        if (dump_end) begin
          state_next = bdq_pkg::ST_CLOSE;
        end
      end
      bdq_pkg::ST_CLOSE: begin
        state_next = bdq_pkg::ST_IDLE;
      end
      default: begin
        state_next = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Queue updates, memory write and result beats.
  always_comb begin
    front_next    = front;
    occ_next      = occ;
    ptr_next      = ptr;
    idx_next      = idx;
    wr_en         = 1'b0;
    wr_addr       = back_addr;
    strobe_next   = 1'b0;
    status_next   = bdq_pkg::STATUS_DONE;
    pos_next      = '0;
    elem_sel_next = 1'b0;
    last_next     = 1'b0;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          unique case (mode)
            bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK: begin
              if (full) begin
                status_next = bdq_pkg::STATUS_FULL;
              end else begin
                wr_en    = 1'b1;
                occ_next = occ + 1'b1;
                if (mode == bdq_pkg::MODE_PUSH_FRONT) begin
                  wr_addr    = front_dec;
                  front_next = front_dec;
                end
              end
            end
            bdq_pkg::MODE_DROP_FIRST, bdq_pkg::MODE_DROP_LAST: begin
              if (empty) begin
                status_next = bdq_pkg::STATUS_EMPTY;
              end else begin
                occ_next = occ - 1'b1;
                if (mode == bdq_pkg::MODE_DROP_FIRST) begin
                  front_next = front_inc;
                end
              end
            end
            bdq_pkg::MODE_DUMP: begin
              ptr_next = front;
              idx_next = '0;
              if (empty) begin
                status_next = bdq_pkg::STATUS_COUNT;
              end else begin
                strobe_next = 1'b0;
                last_next   = 1'b0;
              end
            end
            default: begin
              status_next = bdq_pkg::STATUS_DONE;
            end
          endcase
        end
      end
      bdq_pkg::ST_DUMP: begin
        // The read issued this cycle returns with the registered beat.
        strobe_next   = 1'b1;
        status_next   = bdq_pkg::STATUS_ELEM;
        pos_next      = idx;
        elem_sel_next = 1'b1;
        ptr_next      = ptr_inc;
        idx_next      = idx + 1'b1;
      end
      bdq_pkg::ST_CLOSE: begin
        strobe_next = 1'b1;
        status_next = bdq_pkg::STATUS_COUNT;
        last_next   = 1'b1;
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bdq_pkg::ST_IDLE;
      front  <= '0;
      occ    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      front  <= front_next;
      occ    <= occ_next;
      strobe <= strobe_next;
    end
  end

  // Payload registers of the dump walk and the result beat.
  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    idx      <= idx_next;
    status   <= status_next;
    pos_q    <= pos_next;
    elem_sel <= elem_sel_next;
    last     <= last_next;
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    rd_data <= mem[ptr];
  end

  // Result fields, masked to the port widths.
  assign pos_ext  = {5'b0, pos_q};
  assign cnt_ext  = {6'b0, occ};
  assign position = pos_ext[4:0];
  assign count    = cnt_ext[5:0];
  assign element  = elem_sel ? rd_data : '0;

  // Checks on the queue and result sequencing.
  `BDQ_ASSERT_SAME(a_occ_bound, 1'b1, occ <= CNT_FULL)
  `BDQ_ASSERT_NEXT(a_single_beat, accept && mode != bdq_pkg::MODE_DUMP, strobe && last)
  `BDQ_ASSERT_NEXT(a_no_spurious, !busy && !start, !strobe)
  `BDQ_ASSERT_NEXT(a_dump_keeps_occ, busy, $stable(occ) && $stable(front))

endmodule
